// ===== sv/mopdf_pkg.sv =====
package mopdf_pkg;

	localparam int MAX_ORDERS = 4;

	localparam logic signed [31:0] Q_ONE = 32'sd16777216;
	localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] S32_MIN = 32'sh80000000;

	typedef struct packed {
		logic signed [31:0] energy_liquid;
		logic signed [31:0] energy_solid;
		logic signed [31:0] conc_liquid;
		logic signed [31:0] conc_solid;
		logic signed [31:0] phase_zero;
		logic signed [31:0] phase_one;
		logic signed [31:0] phase_two;
		logic signed [31:0] phase_three;
		logic signed [31:0] rhs_old_one;
		logic signed [31:0] rhs_old_two;
		logic signed [31:0] rhs_old_three;
	} cell_t;

	typedef struct packed {
		logic signed [31:0] rhs_new_one;
		logic signed [31:0] rhs_new_two;
		logic signed [31:0] rhs_new_three;
		logic zero_phase_sum;
	} result_t;

	typedef struct packed {
		logic [2:0] order_count;
		logic signed [31:0] liquid_curvature;
		logic signed [31:0] liquid_equilibrium_conc;
		logic signed [31:0] liquid_energy_scale;
	} cfg_t;

	typedef enum logic [1:0] {
		REG_ORDER_COUNT,
		REG_CURVATURE,
		REG_EQUILIBRIUM_CONC,
		REG_ENERGY_SCALE
	} reg_idx_t;

	localparam logic [2:0] ORDER_COUNT_RESET = 3'd4;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sd2147483647) begin
			r = S32_MAX;
		end else if (x < -64'sd2147483648) begin
			r = S32_MIN;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	// Q8.24 product: round half up at bit 24, then clamp.
	function automatic logic signed [31:0] qround(input logic signed [63:0] p);
		logic signed [63:0] s;
		s = (p + 64'sd8388608) >>> 24;
		return sat32(s);
	endfunction

	function automatic logic [2:0] orders_active(input logic [2:0] cnt);
		logic [2:0] n;
		if (cnt < 3'd2) begin
			n = 3'd2;
		end else if (cnt > 3'(MAX_ORDERS)) begin
			n = 3'(MAX_ORDERS);
		end else begin
			n = cnt;
		end
		return n;
	endfunction

endpackage

// ===== sv/mopdf_delay.sv =====
module mopdf_delay #(
	parameter int W = 1,
	parameter int DEPTH = 1
) (
	input  logic         clk,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_q [DEPTH];

	always_ff @(posedge clk) begin
		line_q[0] <= d;
		for (int k = 1; k < DEPTH; k++) begin
			line_q[k] <= line_q[k-1];
		end
	end

	assign q = line_q[DEPTH-1];

endmodule

// ===== sv/mopdf_div.sv =====
module mopdf_div #(
	parameter int NUM_W = 57,
	parameter int DEN_W = 33,
	parameter int Q_W = 32
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quot
);

	// Restoring long division, one quotient bit per stage. The caller keeps
	// the upper numerator bits (above Q_W) below the divisor.
	logic [DEN_W-1:0] rem_q [Q_W];
	logic [Q_W-1:0]   low_q [Q_W];
	logic [DEN_W-1:0] den_q [Q_W];
	logic [Q_W-1:0]   quo_q [Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		logic [DEN_W-1:0] rem_in;
		logic [Q_W-1:0]   low_in;
		logic [DEN_W-1:0] den_in;
		logic [Q_W-1:0]   quo_in;
		logic [DEN_W:0]   trial;
		logic             ge;

		if (k == 0) begin : g_first
			assign rem_in = DEN_W'(num >> Q_W);
			assign low_in = num[Q_W-1:0];
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign low_in = low_q[k-1];
			assign den_in = den_q[k-1];
			assign quo_in = quo_q[k-1];
		end

		assign trial = {rem_in, low_in[Q_W-1]};
		assign ge = trial >= {1'b0, den_in};

		always_ff @(posedge clk) begin
			rem_q[k] <= ge ? DEN_W'(trial - {1'b0, den_in}) : DEN_W'(trial);
			low_q[k] <= {low_in[Q_W-2:0], 1'b0};
			den_q[k] <= den_in;
			quo_q[k] <= {quo_in[Q_W-2:0], ge};
		end
	end

	assign quot = quo_q[Q_W-1];

endmodule

// ===== sv/mopdf_regs.sv =====
module mopdf_regs (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [3:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	output mopdf_pkg::cfg_t     cfg
);

	mopdf_pkg::cfg_t  cfg_q;
	mopdf_pkg::reg_idx_t idx;

	assign idx = mopdf_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.order_count <= mopdf_pkg::ORDER_COUNT_RESET;
			cfg_q.liquid_curvature <= mopdf_pkg::Q_ONE;
			cfg_q.liquid_equilibrium_conc <= '0;
			cfg_q.liquid_energy_scale <= mopdf_pkg::Q_ONE;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				mopdf_pkg::REG_ORDER_COUNT: cfg_q.order_count <= pwdata[2:0];
				mopdf_pkg::REG_CURVATURE: cfg_q.liquid_curvature <= pwdata;
				mopdf_pkg::REG_EQUILIBRIUM_CONC: cfg_q.liquid_equilibrium_conc <= pwdata;
				mopdf_pkg::REG_ENERGY_SCALE: cfg_q.liquid_energy_scale <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			mopdf_pkg::REG_ORDER_COUNT: prdata = {29'd0, cfg_q.order_count};
			mopdf_pkg::REG_CURVATURE: prdata = cfg_q.liquid_curvature;
			mopdf_pkg::REG_EQUILIBRIUM_CONC: prdata = cfg_q.liquid_equilibrium_conc;
			mopdf_pkg::REG_ENERGY_SCALE: prdata = cfg_q.liquid_energy_scale;
			default: prdata = '0;
		endcase
	end

	assign pready = 1'b1;
	assign cfg = cfg_q;

endmodule

// ===== sv/multi_order_phase_driving_force_unit.sv =====
// Each accepted start leads to the done strobe with its result.
// Throughput: one cell per cycle; busy stays low and the receiver cannot stall.
// The pipeline includes three long dividers of 25, 32 and 33 stages
// (interpolation weights, per-order terms, mean correction).
// Asynchronous reset clears the configuration registers and the pipeline valid bits.
module multi_order_phase_driving_force_unit (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  mopdf_pkg::cell_t     cell_data,
	output logic                 done,
	output mopdf_pkg::result_t   result,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [3:0]           paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready
);

	localparam int LAT = 109;
	localparam int CW = $bits(mopdf_pkg::cell_t);

	mopdf_pkg::cfg_t cfg;
	logic [2:0] n_eff;
	logic [3:1] act;

	mopdf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	assign n_eff = mopdf_pkg::orders_active(cfg.order_count);
	assign act[1] = 1'b1;
	assign act[2] = n_eff >= 3'd3;
	assign act[3] = n_eff >= 3'd4;

	assign busy = 1'b0;

	logic [LAT-1:0] valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			valid_q <= {valid_q[LAT-2:0], start};
		end
	end

	// Stage 1: input capture.
	mopdf_pkg::cell_t in_s1, in_s6, in_s7, in_s34, in_s108;
	logic signed [31:0] phi_s1 [4];

	always_ff @(posedge clk) begin
		in_s1 <= cell_data;
	end

	always_comb begin
		phi_s1[0] = in_s1.phase_zero;
		phi_s1[1] = in_s1.phase_one;
		phi_s1[2] = in_s1.phase_two;
		phi_s1[3] = in_s1.phase_three;
	end

	// Stages 2-5: squares, their sums and the scaled liquid potential.
	logic signed [63:0] sqraw_s2 [4];
	logic signed [31:0] d_s2;
	logic [31:0]        sq_s3 [4];
	logic signed [63:0] adraw_s3;
	logic [31:0]        sl_s4;
	logic [32:0]        ss_s4;
	logic signed [31:0] t_s4;
	logic [31:0]        sl_s5;
	logic [32:0]        ss_s5;
	logic [32:0]        sum_s5;
	logic signed [63:0] muraw_s5;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 4; i++) begin
			sqraw_s2[i] <= phi_s1[i] * phi_s1[i];
			sq_s3[i] <= mopdf_pkg::qround(sqraw_s2[i]);
		end
		d_s2 <= mopdf_pkg::sat32(64'(in_s1.conc_liquid) - 64'(cfg.liquid_equilibrium_conc));
		adraw_s3 <= cfg.liquid_curvature * d_s2;
		sl_s4 <= sq_s3[0];
		ss_s4 <= 33'(sq_s3[1]) + (act[2] ? 33'(sq_s3[2]) : 33'd0)
			+ (act[3] ? 33'(sq_s3[3]) : 33'd0);
		t_s4 <= mopdf_pkg::sat32(64'(mopdf_pkg::qround(adraw_s3)) <<< 1);
		sl_s5 <= sl_s4;
		ss_s5 <= ss_s4;
		sum_s5 <= 33'(sl_s4) + ss_s4;
		muraw_s5 <= t_s4 * cfg.liquid_energy_scale;
	end

	// Stage 6: weight numerators with the rounding half divisor added.
	logic [56:0]        numhl_s6, numhs_s6;
	logic [32:0]        sum_s6;
	logic               zero_s6;
	logic signed [31:0] mu_s6;

	always_ff @(posedge clk) begin
		numhl_s6 <= 57'({sl_s5, 24'd0}) + 57'(sum_s5 >> 1);
		numhs_s6 <= 57'({ss_s5, 24'd0}) + 57'(sum_s5 >> 1);
		sum_s6 <= sum_s5;
		zero_s6 <= sum_s5 == 33'd0;
		mu_s6 <= mopdf_pkg::qround(muraw_s5);
	end

	mopdf_delay #(.W(CW), .DEPTH(5)) u_dly_in6 (.clk(clk), .d(in_s1), .q(in_s6));

	logic [24:0] hl_d31, hs_d31;

	mopdf_div #(.NUM_W(57), .DEN_W(33), .Q_W(25)) u_div_hl (
		.clk(clk), .num(numhl_s6), .den(sum_s6), .quot(hl_d31)
	);
	mopdf_div #(.NUM_W(57), .DEN_W(33), .Q_W(25)) u_div_hs (
		.clk(clk), .num(numhs_s6), .den(sum_s6), .quot(hs_d31)
	);

	// Stages 7-8: driving forces.
	logic signed [63:0] mcraw_s7, mlraw_s7;
	logic signed [31:0] dfs_s8, dfl_s8, dfs_d31, dfl_d31;

	always_ff @(posedge clk) begin
		mcraw_s7 <= mu_s6 * in_s6.conc_solid;
		mlraw_s7 <= mu_s6 * in_s6.conc_liquid;
		in_s7 <= in_s6;
		dfs_s8 <= mopdf_pkg::sat32(64'(in_s7.energy_solid) - 64'(mopdf_pkg::qround(mcraw_s7)));
		dfl_s8 <= mopdf_pkg::sat32(64'(in_s7.energy_liquid)
			- 64'(mopdf_pkg::qround(mlraw_s7)));
	end

	mopdf_delay #(.W(64), .DEPTH(23)) u_dly_df (
		.clk(clk), .d({dfs_s8, dfl_s8}), .q({dfs_d31, dfl_d31})
	);
	mopdf_delay #(.W(CW), .DEPTH(27)) u_dly_in34 (.clk(clk), .d(in_s7), .q(in_s34));

	// Stages 32-36: weighted force g and the per-order products.
	logic signed [63:0] glraw_s32, gsraw_s32;
	logic signed [31:0] gl_s33, gs_s33, g_s34;
	logic signed [31:0] phi_s34 [3:1];
	logic signed [63:0] praw_s35 [3:1];
	logic signed [31:0] p_s36 [3:1];

	always_comb begin
		phi_s34[1] = in_s34.phase_one;
		phi_s34[2] = in_s34.phase_two;
		phi_s34[3] = in_s34.phase_three;
	end

	always_ff @(posedge clk) begin
		glraw_s32 <= $signed({1'b0, hl_d31}) * dfs_d31;
		gsraw_s32 <= $signed({1'b0, hs_d31}) * dfl_d31;
		gl_s33 <= mopdf_pkg::qround(glraw_s32);
		gs_s33 <= mopdf_pkg::qround(gsraw_s32);
		g_s34 <= mopdf_pkg::sat32(64'(gl_s33) + 64'(gs_s33));
		for (int i = 1; i < 4; i++) begin
			praw_s35[i] <= phi_s34[i] * g_s34;
			p_s36[i] <= mopdf_pkg::qround(praw_s35[i]);
		end
	end

	// Stages 37-38: magnitudes times 2^25 plus half the divisor, overflow check.
	logic [32:0] sum_d36, sum_s37, sum_s38;
	logic [56:0] n_s37 [3:1];
	logic [56:0] num_s38 [3:1];
	logic [3:1]  neg_s37, neg_s38, ovf_s38, neg_d70, ovf_d70;

	mopdf_delay #(.W(33), .DEPTH(30)) u_dly_sum (.clk(clk), .d(sum_s6), .q(sum_d36));

	always_ff @(posedge clk) begin
		sum_s37 <= sum_d36;
		sum_s38 <= sum_s37;
		for (int i = 1; i < 4; i++) begin
			neg_s37[i] <= p_s36[i][31];
			n_s37[i] <= 57'({(p_s36[i][31] ? (~p_s36[i] + 32'd1) : p_s36[i]), 25'd0})
				+ 57'(sum_d36 >> 1);
			neg_s38[i] <= neg_s37[i];
			ovf_s38[i] <= 33'(n_s37[i][56:32]) >= sum_s37;
			num_s38[i] <= (33'(n_s37[i][56:32]) >= sum_s37) ? 57'd0 : n_s37[i];
		end
	end

	mopdf_delay #(.W(6), .DEPTH(32)) u_dly_flags (
		.clk(clk), .d({neg_s38, ovf_s38}), .q({neg_d70, ovf_d70})
	);

	logic [31:0] q_d70 [3:1];

	for (genvar i = 1; i < 4; i++) begin : g_term_div
		mopdf_div #(.NUM_W(57), .DEN_W(33), .Q_W(32)) u_div_term (
			.clk(clk), .num(num_s38[i]), .den(sum_s38), .quot(q_d70[i])
		);
	end

	// Stages 71-73: clamped terms, their sum and the rounded dividend for the mean.
	logic signed [31:0] term_s71 [3:1];
	logic signed [33:0] tsum_s72;
	logic [33:0]        tnum_s73;
	logic               tneg_s73, tneg_d106;

	always_ff @(posedge clk) begin
		for (int i = 1; i < 4; i++) begin
			if (!act[i]) begin
				term_s71[i] <= '0;
			end else if (neg_d70[i]) begin
				term_s71[i] <= (ovf_d70[i] || q_d70[i] > 32'h80000000)
					? mopdf_pkg::S32_MIN : $signed(~q_d70[i] + 32'd1);
			end else begin
				term_s71[i] <= (ovf_d70[i] || q_d70[i][31])
					? mopdf_pkg::S32_MAX : $signed(q_d70[i]);
			end
		end
		tsum_s72 <= 34'(term_s71[1]) + 34'(term_s71[2]) + 34'(term_s71[3]);
		tneg_s73 <= tsum_s72[33];
		tnum_s73 <= (tsum_s72[33] ? 34'(-tsum_s72) : 34'(tsum_s72)) + 34'(n_eff >> 1);
	end

	logic [32:0] cq_d106;

	mopdf_div #(.NUM_W(34), .DEN_W(3), .Q_W(33)) u_div_corr (
		.clk(clk), .num(tnum_s73), .den(n_eff), .quot(cq_d106)
	);
	mopdf_delay #(.W(1), .DEPTH(33)) u_dly_tneg (.clk(clk), .d(tneg_s73), .q(tneg_d106));

	logic signed [31:0] term_d107 [3:1];

	mopdf_delay #(.W(96), .DEPTH(36)) u_dly_term (
		.clk(clk),
		.d({term_s71[1], term_s71[2], term_s71[3]}),
		.q({term_d107[1], term_d107[2], term_d107[3]})
	);

	mopdf_delay #(.W(CW), .DEPTH(74)) u_dly_in108 (.clk(clk), .d(in_s34), .q(in_s108));

	logic zero_d108;

	mopdf_delay #(.W(1), .DEPTH(102)) u_dly_zero (.clk(clk), .d(zero_s6), .q(zero_d108));

	// Stages 107-109: mean correction, corrected term, new right-hand sides.
	logic signed [33:0] corr_s107;
	logic signed [31:0] diff_s108 [3:1];
	logic signed [31:0] old_s108 [3:1];
	mopdf_pkg::result_t res_s109;

	always_comb begin
		old_s108[1] = in_s108.rhs_old_one;
		old_s108[2] = in_s108.rhs_old_two;
		old_s108[3] = in_s108.rhs_old_three;
	end

	always_ff @(posedge clk) begin
		corr_s107 <= tneg_d106 ? $signed(34'd0 - 34'(cq_d106)) : $signed(34'(cq_d106));
		for (int i = 1; i < 4; i++) begin
			diff_s108[i] <= mopdf_pkg::sat32(64'(term_d107[i]) - 64'(corr_s107));
		end
		res_s109.zero_phase_sum <= zero_d108;
		res_s109.rhs_new_one <= zero_d108 ? old_s108[1]
			: mopdf_pkg::sat32(64'(old_s108[1]) - 64'(diff_s108[1]));
		res_s109.rhs_new_two <= (zero_d108 || !act[2]) ? old_s108[2]
			: mopdf_pkg::sat32(64'(old_s108[2]) - 64'(diff_s108[2]));
		res_s109.rhs_new_three <= (zero_d108 || !act[3]) ? old_s108[3]
			: mopdf_pkg::sat32(64'(old_s108[3]) - 64'(diff_s108[3]));
	end

	assign result = res_s109;
	assign done = valid_q[LAT-1];

endmodule
